FILE: rtl/core/mtet_pkg.sv
// ----------------------------------------------------------------------------
// mtet_pkg
// Shared types and constants for the timer slot table: transaction payloads,
// command and result codes, and the slot memory word.
// ----------------------------------------------------------------------------
package mtet_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_UNSET = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;

    localparam logic [2:0] KIND_SET_OK   = 3'd0;
    localparam logic [2:0] KIND_SET_FULL = 3'd1;
    localparam logic [2:0] KIND_UNSET    = 3'd2;
    localparam logic [2:0] KIND_FIRED    = 3'd3;
    localparam logic [2:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] event_id;
        logic [30:0] period_ms;
        logic        periodic;
        logic        notify;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] fired_event;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [15:0] event_id;
        logic [30:0] period_ms;
        logic        reload;
        logic        notify;
        logic [31:0] deadline;
    } slot_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        slot_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } ram_rd_t;

endpackage

FILE: rtl/core/mtet_slot_ram.sv
// ----------------------------------------------------------------------------
// mtet_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtet_slot_ram (
    input  logic              aclk,
    input  mtet_pkg::ram_wr_t wr,
    input  mtet_pkg::ram_rd_t rd,
    output mtet_pkg::slot_t   rdata
);

    mtet_pkg::slot_t mem [mtet_pkg::NUM_SLOTS];
    mtet_pkg::slot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/multi_timer_event_table_top.sv
// ----------------------------------------------------------------------------
// multi_timer_event_table_top
// Table of software timer slots driven by time-stamped set, unset and check
// commands.
// ----------------------------------------------------------------------------
// One command is handled at a time. A set's result is loaded into the result
// register once it is free. Unset and check walk the slot memory one slot per
// cycle through its single read port, pausing while a fired event waits for
// the result register to drain. Slot busy flags live in flip-flops and are
// cleared by reset; the remaining slot fields live in the slot memory and are
// only used for busy slots. A check returns one transaction per notifying
// slot that fired, in slot order, with last set on the final one, or a single
// "nothing found" transaction.
// ----------------------------------------------------------------------------
module multi_timer_event_table_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mtet_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mtet_pkg::out_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SET  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                       state_reg, state_next;
    mtet_pkg::in_t                    cmd_reg, cmd_next;
    logic [mtet_pkg::NUM_SLOTS-1:0]   busy_reg, busy_next;
    logic [mtet_pkg::CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                             ev_valid_reg, ev_valid_next;
    logic [mtet_pkg::IDX_W-1:0]       ev_idx_reg, ev_idx_next;
    logic                             pend_valid_reg, pend_valid_next;
    logic [15:0]                      pend_event_reg, pend_event_next;
    logic [mtet_pkg::RES_W-1:0]       res_cnt_reg, res_cnt_next;
    logic                             m_valid_reg, m_valid_next;
    mtet_pkg::out_t                   m_data_reg, m_data_next;

    mtet_pkg::ram_wr_t ram_wr;
    mtet_pkg::ram_rd_t ram_rd;
    mtet_pkg::slot_t   ram_rdata;

    logic                       out_free;
    logic                       out_load;
    mtet_pkg::out_t             out_data;
    logic                       free_found;
    logic [mtet_pkg::IDX_W-1:0] free_idx;
    logic                       slot_busy;
    logic                       fire;
    logic                       emit;
    logic                       stall;

    mtet_slot_ram u_ram (
        .aclk  (aclk),
        .wr    (ram_wr),
        .rd    (ram_rd),
        .rdata (ram_rdata)
    );

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mtet_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = mtet_pkg::IDX_W'(i);
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign slot_busy = busy_reg[ev_idx_reg];
    assign fire      = slot_busy && (ram_rdata.deadline <= cmd_reg.now_ms);
    assign emit      = fire && ram_rdata.notify &&
                       (res_cnt_reg < mtet_pkg::RES_W'(mtet_pkg::MAX_RESULTS));
    // a second notification can only move on once the held one has a place to go
    assign stall     = (state_reg == ST_SCAN) && ev_valid_reg &&
                       (cmd_reg.cmd == mtet_pkg::CMD_CHECK) &&
                       emit && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        busy_next       = busy_reg;
        rd_cnt_next     = rd_cnt_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_event_next = pend_event_reg;
        res_cnt_next    = res_cnt_reg;

        ram_wr.en   = 1'b0;
        ram_wr.addr = ev_idx_reg;
        ram_wr.data = ram_rdata;
        ram_rd.en   = 1'b0;
        ram_rd.addr = rd_cnt_reg[mtet_pkg::IDX_W-1:0];

        out_load             = 1'b0;
        out_data.kind        = mtet_pkg::KIND_NONE;
        out_data.fired_event = '0;
        out_data.last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_data;
                    rd_cnt_next     = '0;
                    ev_valid_next   = 1'b0;
                    pend_valid_next = 1'b0;
                    res_cnt_next    = '0;
                    case (s_data.cmd)
                        mtet_pkg::CMD_SET:   state_next = ST_SET;
                        mtet_pkg::CMD_UNSET: state_next = ST_SCAN;
                        mtet_pkg::CMD_CHECK: state_next = ST_SCAN;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SET: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (free_found) begin
                        ram_wr.en            = 1'b1;
                        ram_wr.addr          = free_idx;
                        ram_wr.data.event_id = cmd_reg.event_id;
                        ram_wr.data.period_ms = cmd_reg.period_ms;
                        ram_wr.data.reload   = cmd_reg.periodic;
                        ram_wr.data.notify   = cmd_reg.notify;
                        ram_wr.data.deadline = cmd_reg.now_ms + {1'b0, cmd_reg.period_ms};
                        busy_next[free_idx]  = 1'b1;
                        out_data.kind        = mtet_pkg::KIND_SET_OK;
                    end else begin
                        out_data.kind = mtet_pkg::KIND_SET_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    // evaluate the slot whose read data has just arrived
                    if (ev_valid_reg) begin
                        if (cmd_reg.cmd == mtet_pkg::CMD_UNSET) begin
                            if (slot_busy && (ram_rdata.event_id == cmd_reg.event_id)) begin
                                busy_next[ev_idx_reg] = 1'b0;
                            end
                        end else if (fire) begin
                            if (emit) begin
                                if (pend_valid_reg) begin
                                    out_load             = 1'b1;
                                    out_data.kind        = mtet_pkg::KIND_FIRED;
                                    out_data.fired_event = pend_event_reg;
                                    out_data.last        = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_event_next = ram_rdata.event_id;
                                res_cnt_next    = res_cnt_reg + 1'b1;
                            end
                            if (ram_rdata.reload) begin
                                ram_wr.en            = 1'b1;
                                ram_wr.data.deadline = cmd_reg.now_ms +
                                                       {1'b0, ram_rdata.period_ms};
                            end else begin
                                busy_next[ev_idx_reg] = 1'b0;
                            end
                        end
                    end
                    // issue the next read
                    if (rd_cnt_reg < mtet_pkg::CNT_W'(mtet_pkg::NUM_SLOTS)) begin
                        ram_rd.en     = 1'b1;
                        ev_valid_next = 1'b1;
                        ev_idx_next   = rd_cnt_reg[mtet_pkg::IDX_W-1:0];
                        rd_cnt_next   = rd_cnt_reg + 1'b1;
                    end else begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (cmd_reg.cmd == mtet_pkg::CMD_UNSET) begin
                        out_data.kind = mtet_pkg::KIND_UNSET;
                    end else if (pend_valid_reg) begin
                        out_data.kind        = mtet_pkg::KIND_FIRED;
                        out_data.fired_event = pend_event_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_data;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_data_next  = m_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            rd_cnt_reg     <= '0;
            ev_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            rd_cnt_reg     <= rd_cnt_next;
            ev_valid_reg   <= ev_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_cnt_reg    <= res_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        ev_idx_reg     <= ev_idx_next;
        pend_event_reg <= pend_event_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/mtet_checker.sv
// ----------------------------------------------------------------------------
// mtet_port_checks
// Port-level checks for the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
module mtet_port_checks (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input mtet_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input mtet_pkg::out_t m_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // only fired events can be followed by more results of the same command
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != mtet_pkg::KIND_FIRED) |-> m_data.last)
        else $error("non-fired result without last");

    a_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind != mtet_pkg::KIND_FIRED) |-> (m_data.fired_event == 16'd0))
        else $error("event id on a non-fired result");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind <= mtet_pkg::KIND_NONE))
        else $error("result kind out of range");

    // a real command closes the input side once it is accepted
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        ((s_data.cmd == mtet_pkg::CMD_SET) || (s_data.cmd == mtet_pkg::CMD_UNSET) ||
         (s_data.cmd == mtet_pkg::CMD_CHECK)) |=> !s_ready)
        else $error("new command accepted during work");

endmodule

bind multi_timer_event_table_top mtet_port_checks u_mtet_port_checks (.*);
